@@ rtl/crt_pkg.sv @@
// ----------------------------------------------------------------------------
// crt_pkg
// Shared constants and step tables for the Catmull-Rom tessellator.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int COORD_BITS  = 32;
    localparam int MAX_SUBDIV  = 31;
    localparam int QUEUE_DEPTH = 2;
    localparam int SUB_BITS    = 5;
    localparam int FRAC_BITS   = 16;
    localparam logic [SUB_BITS-1:0] SUB_RESET = 5'd8;

    // whole part of 65536 / sub
    function automatic logic [FRAC_BITS:0] sub_quot(input logic [SUB_BITS-1:0] sub);
        logic [FRAC_BITS:0] q;
        unique case (sub)
            5'd1:  q = 17'd65536;
            5'd2:  q = 17'd32768;
            5'd3:  q = 17'd21845;
            5'd4:  q = 17'd16384;
            5'd5:  q = 17'd13107;
            5'd6:  q = 17'd10922;
            5'd7:  q = 17'd9362;
            5'd8:  q = 17'd8192;
            5'd9:  q = 17'd7281;
            5'd10: q = 17'd6553;
            5'd11: q = 17'd5957;
            5'd12: q = 17'd5461;
            5'd13: q = 17'd5041;
            5'd14: q = 17'd4681;
            5'd15: q = 17'd4369;
            5'd16: q = 17'd4096;
            5'd17: q = 17'd3855;
            5'd18: q = 17'd3640;
            5'd19: q = 17'd3449;
            5'd20: q = 17'd3276;
            5'd21: q = 17'd3120;
            5'd22: q = 17'd2978;
            5'd23: q = 17'd2849;
            5'd24: q = 17'd2730;
            5'd25: q = 17'd2621;
            5'd26: q = 17'd2520;
            5'd27: q = 17'd2427;
            5'd28: q = 17'd2340;
            5'd29: q = 17'd2259;
            5'd30: q = 17'd2184;
            5'd31: q = 17'd2114;
            default: q = '0;
        endcase
        return q;
    endfunction

    // remainder of 65536 / sub
    function automatic logic [SUB_BITS-1:0] sub_rem(input logic [SUB_BITS-1:0] sub);
        logic [SUB_BITS-1:0] r;
        unique case (sub)
            5'd3, 5'd5, 5'd15, 5'd17: r = 5'd1;
            5'd7, 5'd14, 5'd31:       r = 5'd2;
            5'd13:                    r = 5'd3;
            5'd6, 5'd12:              r = 5'd4;
            5'd19:                    r = 5'd5;
            5'd10:                    r = 5'd6;
            5'd9, 5'd27:              r = 5'd7;
            5'd11, 5'd23:             r = 5'd9;
            5'd25:                    r = 5'd11;
            5'd18, 5'd20, 5'd21, 5'd24, 5'd26, 5'd28, 5'd30: r = 5'd16;
            5'd22:                    r = 5'd20;
            5'd29:                    r = 5'd25;
            default:                  r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/crt_if.sv @@
// ----------------------------------------------------------------------------
// crt_point_if / crt_curve_if
// Valid-ready channels for control points and curve points.
// ----------------------------------------------------------------------------
interface crt_point_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic                 final_point;

    modport source (output valid, point_x, point_y, point_z, final_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, final_point, output ready);
endinterface

interface crt_curve_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] curve_x;
    logic signed [CW-1:0] curve_y;
    logic signed [CW-1:0] curve_z;
    logic                 curve_end;

    modport source (output valid, curve_x, curve_y, curve_z, curve_end, input ready);
    modport sink   (input valid, curve_x, curve_y, curve_z, curve_end, output ready);
endinterface

@@ rtl/crt_front.sv @@
// ----------------------------------------------------------------------------
// crt_front
// Keeps the point history and turns each control point into segment jobs.
// ----------------------------------------------------------------------------
module crt_front
    import crt_pkg::*;
#(
    parameter int CW = COORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    crt_point_if.sink            i_point,
    output logic                 o_push,
    output logic [12*CW+1:0]     o_job,
    input  logic                 i_full
);
    localparam int PW = 3 * CW;
    localparam int JW = 4 * PW + 2;

    logic [PW-1:0] r_hist [3];
    logic [1:0]    r_seen;
    logic [JW-1:0] r_jobs [3];
    logic [1:0]    r_njobs;
    logic [1:0]    r_idx;

    logic [JW-1:0] n_jobs [3];
    logic [1:0]    n_njobs;
    logic [PW-1:0] w_np, w_a, w_b, w_c;
    logic          w_accept, w_last;

    assign w_np     = {i_point.point_x, i_point.point_y, i_point.point_z};
    assign w_last   = i_point.final_point;
    assign i_point.ready = (r_idx == r_njobs);
    assign w_accept = i_point.valid && i_point.ready;
    assign w_a = r_hist[0];
    assign w_b = (r_seen == 2'd2) ? r_hist[0] : r_hist[1];
    assign w_c = (r_seen == 2'd2) ? r_hist[1] : r_hist[2];

    // job: {single point, end of polyline, p0, p1, p2, p3}
    always_comb begin
        n_jobs[0] = {1'b0, 1'b0, w_a, w_b, w_c, w_np};
        n_jobs[1] = {1'b0, 1'b0, w_b, w_c, w_np, w_np};
        n_jobs[2] = {1'b1, 1'b1, w_np, w_np, w_np, w_np};
        n_njobs   = 2'd0;
        priority if (r_seen[1]) begin
            n_njobs = w_last ? 2'd3 : 2'd1;
        end else if (w_last && r_seen[0]) begin
            n_jobs[0] = {1'b1, 1'b0, r_hist[0], r_hist[0], r_hist[0], r_hist[0]};
            n_jobs[1] = n_jobs[2];
            n_njobs   = 2'd2;
        end else if (w_last) begin
            n_jobs[0] = n_jobs[2];
            n_njobs   = 2'd1;
        end else begin
            n_njobs   = 2'd0;
        end
    end

    assign o_push = (r_idx != r_njobs) && !i_full;
    assign o_job  = r_jobs[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_njobs <= '0;
            r_idx   <= '0;
            for (int k = 0; k < 3; k++) r_hist[k] <= '0;
        end else if (w_accept) begin
            for (int k = 0; k < 3; k++) r_jobs[k] <= n_jobs[k];
            r_njobs <= n_njobs;
            r_idx   <= '0;
            if (w_last) begin
                r_seen <= '0;
                for (int k = 0; k < 3; k++) r_hist[k] <= '0;
            end else if (r_seen != 2'd3) begin
                r_hist[r_seen] <= w_np;
                r_seen         <= r_seen + 2'd1;
            end else begin
                r_hist[0] <= r_hist[1];
                r_hist[1] <= r_hist[2];
                r_hist[2] <= w_np;
            end
        end else if (o_push) begin
            r_idx <= r_idx + 2'd1;
        end
    end
endmodule

@@ rtl/crt_queue.sv @@
// ----------------------------------------------------------------------------
// crt_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module crt_queue
    import crt_pkg::*;
#(
    parameter int W     = 12 * COORD_BITS + 2,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    logic [W-1:0]   r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CNW-1:0] r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == CNW'(DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CNW'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CNW'(1);
        end
    end
endmodule

@@ rtl/crt_back.sv @@
// ----------------------------------------------------------------------------
// crt_back
// Steps t across a job and evaluates the cubic per axis in Horner form.
// ----------------------------------------------------------------------------
module crt_back
    import crt_pkg::*;
#(
    parameter int CW = COORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [12*CW+1:0]     i_job,
    input  logic                 i_empty,
    output logic                 o_pop,
    input  logic [SUB_BITS-1:0]  i_sub,
    crt_curve_if.source          o_curve
);
    localparam int PW = 3 * CW;
    localparam int JW = 4 * PW + 2;
    localparam int VW = CW + 5;
    localparam int MW = VW + FRAC_BITS + 1;

    logic                  r_busy, r_end;
    logic [SUB_BITS-1:0]   r_cnt, r_sub, r_r, r_rs;
    logic [FRAC_BITS:0]    r_q, r_qs;
    logic                  r_v1, r_v2, r_v3, r_ov, r_e1, r_e2, r_e3, r_oe;
    logic [FRAC_BITS-1:0]  r_t1, r_t2;

    logic                  w_pt, w_drain, w_load, w_en, w_issue;
    logic [SUB_BITS-1:0]   w_n;
    logic [SUB_BITS:0]     w_rsum;

    assign w_pt    = i_job[JW-1];
    assign w_n     = w_pt ? SUB_BITS'(1) : i_sub;
    assign w_drain = !r_busy && !r_v1 && !r_v2 && !r_v3;
    assign w_load  = w_drain && !i_empty;
    assign o_pop   = w_load;
    assign w_en    = !r_ov || o_curve.ready;
    assign w_issue = r_busy && w_en;
    assign w_rsum  = {1'b0, r_r} + {1'b0, r_rs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= (w_n != '0);
            end else if (w_issue && r_cnt == SUB_BITS'(1)) begin
                r_busy <= 1'b0;
            end
            if (w_en) begin
                r_v1 <= w_issue;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_ov <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cnt <= w_n;
            r_end <= i_job[JW-2];
            r_sub <= i_sub;
            r_q   <= '0;
            r_r   <= '0;
            r_qs  <= sub_quot(i_sub);
            r_rs  <= sub_rem(i_sub);
        end else if (w_issue) begin
            r_cnt <= r_cnt - SUB_BITS'(1);
            if (w_rsum >= {1'b0, r_sub}) begin
                r_r <= SUB_BITS'(w_rsum - {1'b0, r_sub});
                r_q <= r_q + r_qs + 17'd1;
            end else begin
                r_r <= w_rsum[SUB_BITS-1:0];
                r_q <= r_q + r_qs;
            end
        end
        if (w_en) begin
            r_e1 <= r_end && (r_cnt == SUB_BITS'(1));
            r_t1 <= r_q[FRAC_BITS-1:0];
            r_e2 <= r_e1;
            r_t2 <= r_t1;
            r_e3 <= r_e2;
            r_oe <= r_e3;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic signed [VW-1:0] r_c3, r_c2, r_c1, r_c0;
        logic signed [MW-1:0] r_m1, r_m2, r_m3;
        logic signed [CW-1:0] r_o;
        logic signed [VW-1:0] w_p0, w_p1, w_p2, w_p3, w_v1, w_v2, w_v3, w_h;
        logic signed [FRAC_BITS:0] w_t0, w_t1, w_t2;
        logic signed [MW-1:0] w_m1, w_m2, w_m3;

        assign w_p0 = VW'($signed(i_job[4*PW-1-g*CW -: CW]));
        assign w_p1 = VW'($signed(i_job[3*PW-1-g*CW -: CW]));
        assign w_p2 = VW'($signed(i_job[2*PW-1-g*CW -: CW]));
        assign w_p3 = VW'($signed(i_job[PW-1-g*CW -: CW]));

        assign w_t0 = $signed({1'b0, r_q[FRAC_BITS-1:0]});
        assign w_t1 = $signed({1'b0, r_t1});
        assign w_t2 = $signed({1'b0, r_t2});

        assign w_m1 = r_c3 * w_t0;
        assign w_v1 = VW'(r_m1 >>> FRAC_BITS) + r_c2;
        assign w_m2 = w_v1 * w_t1;
        assign w_v2 = VW'(r_m2 >>> FRAC_BITS) + r_c1;
        assign w_m3 = w_v2 * w_t2;
        assign w_v3 = VW'(r_m3 >>> FRAC_BITS) + r_c0;
        assign w_h  = w_v3 >>> 1;

        always_ff @(posedge i_clk) begin
            if (w_load) begin
                r_c0 <= w_p1 <<< 1;
                r_c1 <= w_p2 - w_p0;
                r_c2 <= (w_p0 <<< 1) - (w_p1 <<< 2) - w_p1 + (w_p2 <<< 2) - w_p3;
                r_c3 <= (w_p1 <<< 1) + w_p1 - (w_p2 <<< 1) - w_p2 + w_p3 - w_p0;
            end
            if (w_en) begin
                r_m1 <= w_m1;
                r_m2 <= w_m2;
                r_m3 <= w_m3;
                // saturate to the coordinate range
                if (w_h[VW-1:CW-1] == '0 || w_h[VW-1:CW-1] == '1) begin
                    r_o <= w_h[CW-1:0];
                end else begin
                    r_o <= {w_h[VW-1], {(CW-1){!w_h[VW-1]}}};
                end
            end
        end
    end

    assign o_curve.valid     = r_ov;
    assign o_curve.curve_x   = g_axis[0].r_o;
    assign o_curve.curve_y   = g_axis[1].r_o;
    assign o_curve.curve_z   = g_axis[2].r_o;
    assign o_curve.curve_end = r_oe;
endmodule

@@ rtl/catmull_rom_tessellator.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_tessellator
// Uniform Catmull-Rom subdivision of a 3-D polyline stream.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                  word
//  i_point   in   point_x/y/z, final_point                 control point
//  o_curve   out  curve_x/y/z, curve_end                   curve point
//  cfg       in   i_cfg_we, i_cfg_wdata (subdivisions)     register write
//
//  A job gives one curve point a cycle while the output does not stall; a job
//  holds the back part from its load until its last point has reached the
//  output register, a job with no points for its load alone.
//  The front takes a control point only after pushing all jobs of the last.
//  Synchronous active-low reset clears history, queue and pipeline.
//  Output stalls freeze the evaluation pipeline; the queue decouples the front.
// ----------------------------------------------------------------------------
module catmull_rom_tessellator
    import crt_pkg::*;
#(
    parameter int COORD_W = COORD_BITS,
    parameter int MAX_SUB = MAX_SUBDIV
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SUB_BITS-1:0] i_cfg_wdata,
    crt_point_if.sink           i_point,
    crt_curve_if.source         o_curve
);
    localparam int JW = 12 * COORD_W + 2;

    logic [SUB_BITS-1:0] r_subdiv;
    logic [SUB_BITS-1:0] w_sub;
    logic                w_push, w_pop, w_full, w_empty;
    logic [JW-1:0]       w_job_in, w_job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subdiv <= SUB_RESET;
        end else if (i_cfg_we) begin
            r_subdiv <= i_cfg_wdata;
        end
    end

    assign w_sub = (r_subdiv > SUB_BITS'(MAX_SUB)) ? SUB_BITS'(MAX_SUB) : r_subdiv;

    crt_front #(.CW(COORD_W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (i_point),
        .o_push  (w_push),
        .o_job   (w_job_in),
        .i_full  (w_full)
    );

    crt_queue #(.W(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    crt_back #(.CW(COORD_W)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_sub   (w_sub),
        .o_curve (o_curve)
    );

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("job pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("job popped from an empty queue");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_curve.valid && !o_curve.ready) |=> (o_curve.valid
            && $stable(o_curve.curve_x) && $stable(o_curve.curve_y)
            && $stable(o_curve.curve_z) && $stable(o_curve.curve_end)))
        else $error("curve word changed while stalled");
`endif
endmodule
